// ===== rtl/mcas_pkg.sv =====
package mcas_pkg;

  localparam logic [4:0]  SIZE_RESET = 5'd16;
  localparam logic [23:0] TOTAL_MAX  = 24'hFFFFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLR,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SCAN_END,
    ST_LD_RD,
    ST_LD_USE,
    ST_EDGE,
    ST_RX_RD,
    ST_RX_A,
    ST_RX_B,
    ST_SRCH_DONE,
    ST_AUG_RD,
    ST_AUG_WR,
    ST_PU_RD,
    ST_PU_WR,
    ST_TOT_RD,
    ST_TOT_ADD,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/mcas_in_if.sv =====
interface mcas_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [3:0]  col_index;
  logic [19:0] cost;
  logic        last_entry;

  modport source (output valid, row_index, col_index, cost, last_entry, input ready);
  modport sink   (input valid, row_index, col_index, cost, last_entry, output ready);
endinterface

// ===== rtl/mcas_out_if.sv =====
interface mcas_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_row;
  logic [3:0]  out_col;
  logic [23:0] total_cost;
  logic        last_pair;

  modport source (output valid, out_row, out_col, total_cost, last_pair, input ready);
  modport sink   (input valid, out_row, out_col, total_cost, last_pair, output ready);
endinterface

// ===== rtl/mcas_ram.sv =====
module mcas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/min_cost_assignment_solver_top.sv =====
// Min-cost assignment solver. Cost entries load one per transaction, one per cycle,
// into a MAX_SIZE x MAX_SIZE cost RAM; the transaction with last_entry set starts a
// solve of size n (size_r clamped to 2..MAX_SIZE) and the input stays not ready
// until all n results have been taken. A solve opens with a clearing pass over the
// potential RAM, then runs up to n rounds of a Dijkstra search with node potentials,
// all done by one sequencer around shared add/compare logic and node RAMs with one
// read and one write port each. Each round scans the nodes for the nearest unvisited
// one, relaxes that node's edges and repeats until none is left, then walks the path
// back from the sink to augment the matching and updates the potentials. The total
// is then summed over the rows, and one result per row is offered, rows ascending,
// with last_pair on row n-1.
module min_cost_assignment_solver_top #(
  parameter int MAX_SIZE  = 16,
  parameter int COST_BITS = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  mcas_in_if.sink      in_ch,
  mcas_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);

  localparam int NODES = 2 * MAX_SIZE + 2;
  localparam int NW    = $clog2(NODES);
  localparam int RW    = $clog2(MAX_SIZE);
  localparam int SW    = $clog2(MAX_SIZE + 1);
  localparam int EW    = SW + 1;
  localparam int AW    = $clog2(MAX_SIZE * MAX_SIZE);
  localparam int CW    = COST_BITS;
  localparam int VW    = COST_BITS + $clog2(MAX_SIZE) + 4;
  localparam int TW    = ((CW > 24) ? CW : 24) + 1;

  function automatic logic [AW-1:0] cost_addr(input logic [31:0] r, input logic [31:0] c);
    logic [31:0] a;
    a = r * MAX_SIZE + c;
    return AW'(a);
  endfunction

  mcas_pkg::state_t state_r, state_nxt;

  logic [4:0]            size_r;
  logic [SW-1:0]         n_r, n_nxt;
  logic [SW-1:0]         round_r, round_nxt;
  logic [NW-1:0]         j_r, j_nxt;
  logic [NW-1:0]         v_r, v_nxt;
  logic [NW-1:0]         t_r, t_nxt;
  logic [NW-1:0]         u_r, u_nxt;
  logic [EW-1:0]         e_r, e_nxt;
  logic                  found_r, found_nxt;
  logic signed [VW-1:0]  best_r, best_nxt;
  logic signed [VW-1:0]  base_r, base_nxt;
  logic signed [VW-1:0]  tmp_r, tmp_nxt;
  logic [AW-1:0]         caddr_r, caddr_nxt;
  logic                  csub_r, csub_nxt;
  logic                  cuse_r, cuse_nxt;
  logic [RW-1:0]         i_r, i_nxt;
  logic [23:0]           total_r, total_nxt;
  logic [NODES-1:0]      visited_r, visited_nxt;
  logic [NODES-1:0]      reached_r, reached_nxt;
  logic [RW-1:0]         rtc_r [MAX_SIZE];
  logic [RW-1:0]         rtc_nxt [MAX_SIZE];
  logic [MAX_SIZE-1:0]   rtc_vld_r, rtc_vld_nxt;
  logic [RW-1:0]         ctr_r [MAX_SIZE];
  logic [RW-1:0]         ctr_nxt [MAX_SIZE];
  logic [MAX_SIZE-1:0]   ctr_vld_r, ctr_vld_nxt;

  // RAM ports
  logic                  cost_we;
  logic [AW-1:0]         cost_waddr, cost_raddr;
  logic [CW-1:0]         cost_wdata, cost_rd;
  logic                  pot_we;
  logic [NW-1:0]         pot_waddr, pot_raddr;
  logic signed [VW-1:0]  pot_wdata, pot_rd;
  logic                  dist_we;
  logic [NW-1:0]         dist_waddr, dist_raddr;
  logic signed [VW-1:0]  dist_wdata, dist_rd;
  logic                  par_we;
  logic [NW-1:0]         par_wdata, par_rd;

  mcas_ram #(.WIDTH(CW), .DEPTH(MAX_SIZE * MAX_SIZE)) u_cost_ram (
    .clk, .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
    .raddr(cost_raddr), .rdata(cost_rd)
  );
  mcas_ram #(.WIDTH(VW), .DEPTH(NODES)) u_pot_ram (
    .clk, .we(pot_we), .waddr(pot_waddr), .wdata(pot_wdata),
    .raddr(pot_raddr), .rdata(pot_rd)
  );
  mcas_ram #(.WIDTH(VW), .DEPTH(NODES)) u_dist_ram (
    .clk, .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rd)
  );
  mcas_ram #(.WIDTH(NW), .DEPTH(NODES)) u_par_ram (
    .clk, .we(par_we), .waddr(t_r), .wdata(par_wdata),
    .raddr(u_r), .rdata(par_rd)
  );

  logic [NW-1:0] sink;
  logic [NW-1:0] n_node;
  logic [RW-1:0] v_row, v_col, e_lo;
  logic          in_acc, in_range;
  logic [7:0]    size_ext;
  logic [SW-1:0] size_clamped;

  assign sink     = NW'({n_r, 1'b1});
  assign n_node   = NW'(n_r);
  assign v_row    = RW'(v_r - NW'(1));
  assign v_col    = RW'(v_r - NW'(1) - n_node);
  assign e_lo     = e_r[RW-1:0];
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_range = (32'(in_ch.row_index) < 32'(MAX_SIZE)) &&
                    (32'(in_ch.col_index) < 32'(MAX_SIZE));
  assign size_ext = 8'(size_r);

  always_comb begin
    if (size_ext < 8'd2) begin
      size_clamped = SW'(2);
    end else if (32'(size_ext) > 32'(MAX_SIZE)) begin
      size_clamped = SW'(MAX_SIZE);
    end else begin
      size_clamped = SW'(size_r);
    end
  end

  assign in_ch.ready       = (state_r == mcas_pkg::ST_IDLE);
  assign out_ch.valid      = (state_r == mcas_pkg::ST_OUT);
  assign out_ch.out_row    = 4'(i_r);
  assign out_ch.out_col    = rtc_vld_r[i_r] ? 4'(rtc_r[i_r]) : 4'd0;
  assign out_ch.total_cost = total_r;
  assign out_ch.last_pair  = (SW'(i_r) == n_r - SW'(1));

  assign cost_we    = in_acc && in_range;
  assign cost_waddr = cost_addr(32'(in_ch.row_index), 32'(in_ch.col_index));
  assign cost_wdata = CW'(in_ch.cost);

  // edge generator for the node being expanded
  logic          ed_end, ed_ok, ed_use, ed_sub;
  logic [NW-1:0] ed_t;
  logic [AW-1:0] ed_ca;

  always_comb begin
    ed_end = 1'b0;
    ed_ok  = 1'b0;
    ed_use = 1'b0;
    ed_sub = 1'b0;
    ed_t   = '0;
    ed_ca  = '0;
    if (v_r == '0) begin
      ed_end = (e_r == EW'(n_r));
      ed_ok  = !rtc_vld_r[e_lo];
      ed_t   = NW'(1) + NW'(e_r);
    end else if (v_r <= n_node) begin
      ed_end = (e_r > EW'(n_r));
      if (e_r == EW'(n_r)) begin
        ed_ok = rtc_vld_r[v_row];
        ed_t  = '0;
      end else begin
        ed_ok  = 1'b1;
        ed_use = 1'b1;
        ed_t   = NW'(1) + n_node + NW'(e_r);
        ed_ca  = cost_addr(32'(v_row), 32'(e_lo));
      end
    end else if (v_r < sink) begin
      ed_end = (e_r != '0);
      ed_ok  = 1'b1;
      if (ctr_vld_r[v_col]) begin
        ed_use = 1'b1;
        ed_sub = 1'b1;
        ed_t   = NW'(1) + NW'(ctr_r[v_col]);
        ed_ca  = cost_addr(32'(ctr_r[v_col]), 32'(v_col));
      end else begin
        ed_t = sink;
      end
    end else begin
      ed_end = (e_r == EW'(n_r));
      ed_ok  = ctr_vld_r[e_lo];
      ed_t   = NW'(1) + n_node + NW'(e_r);
    end
  end

  // shared add/compare step
  logic signed [VW-1:0] cost_s, nd;
  logic                 upd;
  logic [TW-1:0]        tot_sum;
  logic [NW-1:0]        p_row, u_colx;

  assign cost_s  = $signed({{(VW - CW){1'b0}}, cost_rd});
  assign nd      = tmp_r - pot_rd;
  assign upd     = !reached_r[t_r] || (nd < dist_rd);
  assign tot_sum = TW'(total_r) + TW'(cost_rd);
  assign p_row   = par_rd - NW'(1);
  assign u_colx  = u_r - NW'(1) - n_node;

  always_comb begin
    cost_raddr = (state_r == mcas_pkg::ST_TOT_RD || state_r == mcas_pkg::ST_TOT_ADD) ?
                 cost_addr(32'(i_r), 32'(rtc_r[i_r])) : caddr_r;
    case (state_r)
      mcas_pkg::ST_SCAN_RD, mcas_pkg::ST_SCAN_CMP: dist_raddr = j_r;
      mcas_pkg::ST_PU_RD, mcas_pkg::ST_PU_WR:      dist_raddr = j_r;
      default:                                     dist_raddr = t_r;
    endcase
    case (state_r)
      mcas_pkg::ST_LD_RD, mcas_pkg::ST_LD_USE: pot_raddr = v_r;
      mcas_pkg::ST_PU_RD, mcas_pkg::ST_PU_WR:  pot_raddr = j_r;
      default:                                 pot_raddr = t_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    round_nxt   = round_r;
    j_nxt       = j_r;
    v_nxt       = v_r;
    t_nxt       = t_r;
    u_nxt       = u_r;
    e_nxt       = e_r;
    found_nxt   = found_r;
    best_nxt    = best_r;
    base_nxt    = base_r;
    tmp_nxt     = tmp_r;
    caddr_nxt   = caddr_r;
    csub_nxt    = csub_r;
    cuse_nxt    = cuse_r;
    i_nxt       = i_r;
    total_nxt   = total_r;
    visited_nxt = visited_r;
    reached_nxt = reached_r;
    rtc_nxt     = rtc_r;
    rtc_vld_nxt = rtc_vld_r;
    ctr_nxt     = ctr_r;
    ctr_vld_nxt = ctr_vld_r;
    pot_we      = 1'b0;
    pot_waddr   = j_r;
    pot_wdata   = '0;
    dist_we     = 1'b0;
    dist_waddr  = t_r;
    dist_wdata  = nd;
    par_we      = 1'b0;
    par_wdata   = v_r;

    case (state_r)
      mcas_pkg::ST_IDLE: begin
        if (in_acc && in_ch.last_entry) begin
          n_nxt       = size_clamped;
          j_nxt       = '0;
          round_nxt   = '0;
          rtc_vld_nxt = '0;
          ctr_vld_nxt = '0;
          state_nxt   = mcas_pkg::ST_CLR;
        end
      end
      mcas_pkg::ST_CLR: begin
        pot_we = 1'b1;
        j_nxt  = j_r + NW'(1);
        if (j_r == sink) begin
          state_nxt = mcas_pkg::ST_INIT;
        end
      end
      mcas_pkg::ST_INIT: begin
        visited_nxt = '0;
        reached_nxt = NODES'(1);
        dist_we     = 1'b1;
        dist_waddr  = '0;
        dist_wdata  = '0;
        j_nxt       = '0;
        found_nxt   = 1'b0;
        state_nxt   = mcas_pkg::ST_SCAN_RD;
      end
      mcas_pkg::ST_SCAN_RD: begin
        state_nxt = mcas_pkg::ST_SCAN_CMP;
      end
      mcas_pkg::ST_SCAN_CMP: begin
        if (reached_r[j_r] && !visited_r[j_r] && (!found_r || dist_rd < best_r)) begin
          found_nxt = 1'b1;
          best_nxt  = dist_rd;
          v_nxt     = j_r;
        end
        j_nxt     = j_r + NW'(1);
        state_nxt = (j_r == sink) ? mcas_pkg::ST_SCAN_END : mcas_pkg::ST_SCAN_RD;
      end
      mcas_pkg::ST_SCAN_END: begin
        if (!found_r) begin
          state_nxt = mcas_pkg::ST_SRCH_DONE;
        end else begin
          visited_nxt[v_r] = 1'b1;
          state_nxt        = mcas_pkg::ST_LD_RD;
        end
      end
      mcas_pkg::ST_LD_RD: begin
        state_nxt = mcas_pkg::ST_LD_USE;
      end
      mcas_pkg::ST_LD_USE: begin
        base_nxt  = best_r + pot_rd;
        e_nxt     = '0;
        state_nxt = mcas_pkg::ST_EDGE;
      end
      mcas_pkg::ST_EDGE: begin
        if (ed_end) begin
          j_nxt     = '0;
          found_nxt = 1'b0;
          state_nxt = mcas_pkg::ST_SCAN_RD;
        end else if (ed_ok) begin
          t_nxt     = ed_t;
          caddr_nxt = ed_ca;
          cuse_nxt  = ed_use;
          csub_nxt  = ed_sub;
          state_nxt = mcas_pkg::ST_RX_RD;
        end else begin
          e_nxt = e_r + EW'(1);
        end
      end
      mcas_pkg::ST_RX_RD: begin
        state_nxt = mcas_pkg::ST_RX_A;
      end
      mcas_pkg::ST_RX_A: begin
        if (!cuse_r) begin
          tmp_nxt = base_r;
        end else if (csub_r) begin
          tmp_nxt = base_r - cost_s;
        end else begin
          tmp_nxt = base_r + cost_s;
        end
        state_nxt = mcas_pkg::ST_RX_B;
      end
      mcas_pkg::ST_RX_B: begin
        if (upd) begin
          dist_we          = 1'b1;
          par_we           = 1'b1;
          reached_nxt[t_r] = 1'b1;
        end
        e_nxt     = e_r + EW'(1);
        state_nxt = mcas_pkg::ST_EDGE;
      end
      mcas_pkg::ST_SRCH_DONE: begin
        if (!reached_r[sink]) begin
          i_nxt     = '0;
          total_nxt = '0;
          state_nxt = mcas_pkg::ST_TOT_RD;
        end else begin
          u_nxt     = sink;
          j_nxt     = '0;
          state_nxt = mcas_pkg::ST_AUG_RD;
        end
      end
      mcas_pkg::ST_AUG_RD: begin
        state_nxt = mcas_pkg::ST_AUG_WR;
      end
      mcas_pkg::ST_AUG_WR: begin
        // row -> column arc on the path becomes a matched pair
        if (par_rd >= NW'(1) && par_rd <= n_node && u_r > n_node && u_r < sink) begin
          rtc_nxt[RW'(p_row)]      = RW'(u_colx);
          rtc_vld_nxt[RW'(p_row)]  = 1'b1;
          ctr_nxt[RW'(u_colx)]     = RW'(p_row);
          ctr_vld_nxt[RW'(u_colx)] = 1'b1;
        end
        u_nxt = par_rd;
        j_nxt = j_r + NW'(1);
        if (par_rd == '0 || j_r == sink) begin
          j_nxt     = '0;
          state_nxt = mcas_pkg::ST_PU_RD;
        end else begin
          state_nxt = mcas_pkg::ST_AUG_RD;
        end
      end
      mcas_pkg::ST_PU_RD: begin
        state_nxt = mcas_pkg::ST_PU_WR;
      end
      mcas_pkg::ST_PU_WR: begin
        pot_we    = reached_r[j_r];
        pot_wdata = pot_rd + dist_rd;
        j_nxt     = j_r + NW'(1);
        if (j_r == sink) begin
          round_nxt = round_r + SW'(1);
          if (round_r + SW'(1) == n_r) begin
            i_nxt     = '0;
            total_nxt = '0;
            state_nxt = mcas_pkg::ST_TOT_RD;
          end else begin
            state_nxt = mcas_pkg::ST_INIT;
          end
        end else begin
          state_nxt = mcas_pkg::ST_PU_RD;
        end
      end
      mcas_pkg::ST_TOT_RD: begin
        state_nxt = mcas_pkg::ST_TOT_ADD;
      end
      mcas_pkg::ST_TOT_ADD: begin
        if (rtc_vld_r[i_r]) begin
          total_nxt = (tot_sum > TW'(mcas_pkg::TOTAL_MAX)) ? mcas_pkg::TOTAL_MAX
                                                           : tot_sum[23:0];
        end
        if (SW'(i_r) == n_r - SW'(1)) begin
          i_nxt     = '0;
          state_nxt = mcas_pkg::ST_OUT;
        end else begin
          i_nxt     = i_r + RW'(1);
          state_nxt = mcas_pkg::ST_TOT_RD;
        end
      end
      mcas_pkg::ST_OUT: begin
        if (out_ch.ready) begin
          if (SW'(i_r) == n_r - SW'(1)) begin
            state_nxt = mcas_pkg::ST_IDLE;
          end else begin
            i_nxt = i_r + RW'(1);
          end
        end
      end
      default: begin
        state_nxt = mcas_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mcas_pkg::ST_IDLE;
      rtc_vld_r <= '0;
      ctr_vld_r <= '0;
      visited_r <= '0;
      reached_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rtc_vld_r <= rtc_vld_nxt;
      ctr_vld_r <= ctr_vld_nxt;
      visited_r <= visited_nxt;
      reached_r <= reached_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= mcas_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    round_r <= round_nxt;
    j_r     <= j_nxt;
    v_r     <= v_nxt;
    t_r     <= t_nxt;
    u_r     <= u_nxt;
    e_r     <= e_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    base_r  <= base_nxt;
    tmp_r   <= tmp_nxt;
    caddr_r <= caddr_nxt;
    csub_r  <= csub_nxt;
    cuse_r  <= cuse_nxt;
    i_r     <= i_nxt;
    total_r <= total_nxt;
    rtc_r   <= rtc_nxt;
    ctr_r   <= ctr_nxt;
  end

endmodule

// ===== tb/min_cost_assignment_solver_top_tb.sv =====
module min_cost_assignment_solver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSIZE = 16;
  localparam int NODES = 2 * NSIZE + 2;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 80;
  localparam int FILL_SIZE = 8;
  localparam int QDEPTH = 64;
  localparam int TAB_DEPTH = 32;

  typedef struct {
    logic [3:0]  row;
    logic [3:0]  col;
    logic [23:0] total;
    logic        last;
  } pair_t;

  typedef struct {
    bit          is_cfg;
    logic [4:0]  size_val;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [19:0] cost;
    logic        last;
    bit          has_total;
    logic [23:0] total;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  mcas_in_if  in_ch ();
  mcas_out_if out_ch ();

  min_cost_assignment_solver_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [19:0] cost_mem [NSIZE][NSIZE];
  longint      pot [NODES];
  longint      node_dist [NODES];
  int          par [NODES];
  bit          seen [NODES];
  bit          done_node [NODES];
  int          row_mate [NSIZE];
  int          col_mate [NSIZE];
  logic [4:0]  size_reg;

  // expected pairs, ring indexed by q_wr/q_rd
  pair_t       exp_q [QDEPTH];
  int          q_wr;
  int          q_rd;
  stim_row_t   dir_tab [TAB_DEPTH];
  int          dir_cnt;
  int          errors;
  int          pairs_checked;
  int          solves;
  int          items_sent;
  int          send_idle_pct;
  int          stall_pct;
  bit          hold_req;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void relax(int v, int t, longint len);
    longint nd;
    nd = node_dist[v] + len;
    if (!seen[t] || nd < node_dist[t]) begin
      seen[t] = 1'b1;
      node_dist[t] = nd;
      par[t] = v;
    end
  endfunction

  function automatic void shortest_path(int n);
    int sink;
    int v;
    sink = 2 * n + 1;
    for (int k = 0; k < NODES; k++) begin
      seen[k] = 1'b0;
      done_node[k] = 1'b0;
    end
    seen[0] = 1'b1;
    node_dist[0] = 0;
    par[0] = 0;
    for (int i = 0; i < 2 * n + 2; i++) begin
      v = -1;
      for (int j = 0; j < 2 * n + 2; j++)
        if (!done_node[j] && seen[j] && (v < 0 || node_dist[j] < node_dist[v]))
          v = j;
      if (v < 0)
        break;
      done_node[v] = 1'b1;
      if (v == 0) begin
        for (int j = 0; j < n; j++)
          if (row_mate[j] < 0)
            relax(v, 1 + j, pot[0] - pot[1 + j]);
      end else if (v <= n) begin
        if (row_mate[v - 1] >= 0)
          relax(v, 0, pot[v] - pot[0]);
        for (int j = 0; j < n; j++)
          relax(v, 1 + n + j, longint'(cost_mem[v - 1][j]) + pot[v] - pot[1 + n + j]);
      end else if (v < sink) begin
        if (col_mate[v - 1 - n] < 0)
          relax(v, sink, pot[v] - pot[sink]);
        else
          relax(v, 1 + col_mate[v - 1 - n],
                -longint'(cost_mem[col_mate[v - 1 - n]][v - 1 - n]) + pot[v]
                - pot[1 + col_mate[v - 1 - n]]);
      end else begin
        for (int j = 0; j < n; j++)
          if (col_mate[j] >= 0)
            relax(v, 1 + n + j, pot[sink] - pot[1 + n + j]);
      end
    end
  endfunction

  // Store one entry; on the last one solve and queue the n expected pairs.
  function automatic void predict_entry(logic [3:0] r, logic [3:0] c, logic [19:0] w,
                                        logic last);
    int n;
    int sink;
    int u;
    int p;
    longint sum;
    pair_t e;
    cost_mem[r][c] = w;
    if (!last)
      return;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > NSIZE) n = NSIZE;
    sink = 2 * n + 1;
    for (int k = 0; k < NODES; k++) pot[k] = 0;
    for (int k = 0; k < NSIZE; k++) begin
      row_mate[k] = -1;
      col_mate[k] = -1;
    end
    for (int rnd = 0; rnd < n; rnd++) begin
      shortest_path(n);
      if (!seen[sink])
        break;
      u = sink;
      for (int k = 0; k < 2 * n + 2 && u != 0; k++) begin
        p = par[u];
        if (p >= 1 && p <= n && u > n && u < sink) begin
          row_mate[p - 1] = u - 1 - n;
          col_mate[u - 1 - n] = p - 1;
        end
        u = p;
      end
      for (int k = 0; k < 2 * n + 2; k++)
        if (seen[k])
          pot[k] += node_dist[k];
    end
    sum = 0;
    for (int i = 0; i < n; i++)
      if (row_mate[i] >= 0) begin
        sum += cost_mem[i][row_mate[i]];
        if (sum > mcas_pkg::TOTAL_MAX) sum = mcas_pkg::TOTAL_MAX;
      end
    for (int i = 0; i < n; i++) begin
      e.row = i[3:0];
      e.col = row_mate[i] < 0 ? 4'd0 : row_mate[i][3:0];
      e.total = sum[23:0];
      e.last = (i == n - 1);
      exp_q[q_wr % QDEPTH] = e;
      q_wr++;
    end
    solves++;
  endfunction

  function automatic void set_pending_total(logic [23:0] total);
    for (int k = q_rd; k < q_wr; k++)
      exp_q[k % QDEPTH].total = total;
  endfunction

  task automatic send_entry(logic [3:0] r, logic [3:0] c, logic [19:0] w, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.row_index  <= r;
    in_ch.col_index  <= c;
    in_ch.cost       <= w;
    in_ch.last_entry <= last;
    do @(posedge clk); while (!in_ch.ready);
    predict_entry(r, c, w, last);
    items_sent++;
  endtask

  task automatic write_size(logic [4:0] val);
    in_ch.valid <= 1'b0;
    wait (q_wr == q_rd);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg = val;
  endtask

  function automatic void add_row(bit is_cfg, logic [4:0] sv, logic [3:0] r,
                                  logic [3:0] c, logic [19:0] w, logic last,
                                  bit has_total, logic [23:0] total);
    stim_row_t s;
    s.is_cfg = is_cfg; s.size_val = sv; s.row = r; s.col = c; s.cost = w;
    s.last = last; s.has_total = has_total; s.total = total;
    dir_tab[dir_cnt] = s;
    dir_cnt++;
  endfunction

  function automatic logic [19:0] rand_cost();
    case ($urandom_range(0, 4))
      0: return 20'd0;
      1: return 20'hFFFFF;
      2: return 20'($urandom_range(0, 15));
      default: return 20'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    pair_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pairs_checked++;
      if (q_wr == q_rd) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pair row=%0d col=%0d total=%0d last=%0b",
                   out_ch.out_row, out_ch.out_col, out_ch.total_cost, out_ch.last_pair);
      end else begin
        e = exp_q[q_rd % QDEPTH];
        q_rd++;
        if (out_ch.out_row !== e.row || out_ch.out_col !== e.col ||
            out_ch.total_cost !== e.total || out_ch.last_pair !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp row=%0d col=%0d total=%0d last=%0b, got %0d %0d %0d %0b",
                     e.row, e.col, e.total, e.last, out_ch.out_row, out_ch.out_col,
                     out_ch.total_cost, out_ch.last_pair);
        end
      end
    end
  end

  // long receiver hold: starts on the first offered pair once requested
  int hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (out_ch.valid) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0 || (hold_req && !hold_done))
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pairs pending", cycles, q_wr - q_rd);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    int cnt;
    int set_no;
    logic [4:0] sv;
    logic [3:0] r;
    logic [3:0] c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.row_index = '0;
    in_ch.col_index = '0;
    in_ch.cost = '0;
    in_ch.last_entry = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0; pairs_checked = 0; solves = 0; items_sent = 0;
    send_idle_pct = 0; stall_pct = 0; hold_req = 1'b0;
    hold_left = 0; hold_done = 1'b0; cycles = 0;
    q_wr = 0; q_rd = 0; dir_cnt = 0;
    size_reg = mcas_pkg::SIZE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the leading 8 x 8 block with the maximum cost and solve it
    write_size(5'(FILL_SIZE));
    for (int i = 0; i < FILL_SIZE * FILL_SIZE; i++)
      send_entry(4'(i / FILL_SIZE), 4'(i % FILL_SIZE), 20'hFFFFF,
                 i == FILL_SIZE * FILL_SIZE - 1);
    set_pending_total(24'd8388600);

    add_row(1, 5'd2, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 20'hFFFFF, 0, 0, 0);
    add_row(0, 0, 0, 1, 20'hFFFFF, 0, 0, 0);
    add_row(0, 0, 1, 0, 20'hFFFFF, 0, 0, 0);
    add_row(0, 0, 1, 1, 20'hFFFFF, 1, 1, 24'd2097150);
    add_row(0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 1, 0, 0, 0, 0);
    add_row(0, 0, 1, 0, 0, 0, 0, 0);
    add_row(0, 0, 1, 1, 0, 1, 1, 24'd0);
    // entries beyond the active size are stored but ignored
    add_row(0, 0, 4'd15, 4'd15, 20'd0, 0, 0, 0);
    add_row(0, 0, 4'd5, 4'd9, 20'd123, 0, 0, 0);
    add_row(0, 0, 1, 1, 20'd7, 1, 0, 0);
    // size below range clamps to 2
    add_row(1, 5'd0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 20'd5, 0, 0, 0);
    add_row(0, 0, 0, 1, 20'd1, 0, 0, 0);
    add_row(0, 0, 1, 0, 20'd2, 0, 0, 0);
    add_row(0, 0, 1, 1, 20'd9, 1, 1, 24'd3);
    // repeated solve reuses the store
    add_row(1, 5'd1, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 0, 20'd0, 1, 1, 24'd3);

    for (int i = 0; i < dir_cnt; i++) begin
      if (dir_tab[i].is_cfg)
        write_size(dir_tab[i].size_val);
      else begin
        send_entry(dir_tab[i].row, dir_tab[i].col, dir_tab[i].cost, dir_tab[i].last);
        if (dir_tab[i].has_total)
          set_pending_total(dir_tab[i].total);
      end
    end

    // random matrices, idle pattern rotating per set
    cnt = 0;
    set_no = 0;
    while (cnt < RANDOM_ITEMS) begin
      case (set_no % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      // set 2 keeps offering entries while the receiver holds off
      if (set_no != 2 && (set_no == 0 || $urandom_range(0, 1))) begin
        case ($urandom_range(0, 9))
          0: sv = 5'($urandom_range(0, 1));
          1: sv = 5'($urandom_range(6, FILL_SIZE));
          default: sv = 5'($urandom_range(2, 5));
        endcase
        write_size(sv);
      end
      if (set_no == 1) hold_req = 1'b1;
      n = size_reg < 2 ? 2 : (size_reg > NSIZE ? NSIZE : size_reg);
      repeat (n <= 5 ? $urandom_range(1, n * n + 2) : $urandom_range(1, 6)) begin
        if ($urandom_range(0, 4) == 0) begin
          r = 4'($urandom); c = 4'($urandom);
        end else begin
          r = 4'($urandom_range(0, n - 1)); c = 4'($urandom_range(0, n - 1));
        end
        send_entry(r, c, rand_cost(), 1'b0);
        cnt++;
      end
      send_entry(4'($urandom), 4'($urandom), rand_cost(), 1'b1);
      cnt++;
      set_no++;
    end
    in_ch.valid <= 1'b0;

    wait (q_wr == q_rd);
    repeat (200) @(posedge clk);
    $display("%0d entries loaded, %0d solves, %0d pairs checked",
             items_sent, solves, pairs_checked);
    $display("sizes 2 to 8 incl. clamping from below, idle/stall phases, one long hold");
    if (errors == 0 && q_wr == q_rd)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcas_pkg.sv
rtl/mcas_in_if.sv
rtl/mcas_out_if.sv
rtl/mcas_ram.sv
rtl/min_cost_assignment_solver_top.sv
tb/min_cost_assignment_solver_top_tb.sv
